// File: rtl/core/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

  localparam int MAX_FIELDS = 32;
  // comma counter saturates at MAX_FIELDS - 1, field count reaches MAX_FIELDS
  localparam int COMMA_W = $clog2(MAX_FIELDS);
  localparam int COUNT_W = $clog2(MAX_FIELDS + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [23:0] TAG_RMC = 24'h524D43;
  localparam logic [23:0] TAG_GGA = 24'h474741;
  localparam logic [23:0] TAG_MWV = 24'h4D5756;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_BAD_SUM      = 3'd2,
    ST_SHORT_HDR    = 3'd3,
    ST_UNKNOWN_TYPE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_RMC     = 2'd1,
    KIND_GGA     = 2'd2,
    KIND_MWV     = 2'd3
  } kind_t;

  // {valid, nibble}; invalid characters give nibble 0
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/nmea_sentence_checker_unit.sv
`default_nettype none

// NMEA 0183 sentence checker. Takes one sentence byte per beat, last marking the
// final byte, and delivers one verdict beat per sentence in the cycle after its
// last byte is taken. Throughput is one byte per clock: the per-byte state update
// is a single register stage, and the verdict sits in an output register, so
// in_ready drops only while a verdict waits for out_ready. After a verdict the
// scanner is back in its reset state and the next byte starts a new sentence.
module nmea_sentence_checker_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_req,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [1:0]      sentence_kind,
  output logic            checksum_ok,
  output logic [5:0]      field_count
);

  // scanner state
  logic                           at_first_byte, at_first_byte_next;
  logic                           start_good, start_good_next;
  logic                           star_seen, star_seen_next;
  logic [1:0]                     hex_digits_taken, hex_digits_taken_next;
  logic [7:0]                     running_xor, running_xor_next;
  logic [7:0]                     given_sum, given_sum_next;
  logic                           hex_invalid, hex_invalid_next;
  logic                           in_header, in_header_next;
  logic [23:0]                    header_tail, header_tail_next;
  logic [1:0]                     header_length, header_length_next;
  logic [nsc_pkg::COMMA_W-1:0]    comma_total, comma_total_next;

  // state after this byte, before the end-of-sentence clear
  logic                           t_start_good, t_star_seen, t_hex_invalid, t_in_header;
  logic [1:0]                     t_hex_taken, t_hdr_len;
  logic [7:0]                     t_xor, t_sum;
  logic [23:0]                    t_tail;
  logic [nsc_pkg::COMMA_W-1:0]    t_commas;
  logic [4:0]                     nib;

  // verdict
  nsc_pkg::status_t               v_status, status_q;
  nsc_pkg::kind_t                 v_kind, kind_q;
  logic                           v_ok, ok_q;
  logic [nsc_pkg::COUNT_W-1:0]    v_count;
  logic [7:0]                     v_count8;
  logic [5:0]                     count_q;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    t_start_good  = start_good;
    t_star_seen   = star_seen;
    t_hex_invalid = hex_invalid;
    t_in_header   = in_header;
    t_hex_taken   = hex_digits_taken;
    t_hdr_len     = header_length;
    t_xor         = running_xor;
    t_sum         = given_sum;
    t_tail        = header_tail;
    t_commas      = comma_total;
    nib           = nsc_pkg::hex_nibble(byte_req);
    if (at_first_byte) begin
      t_start_good = (byte_req == nsc_pkg::CH_DOLLAR);
    end else if (!star_seen) begin
      if (byte_req == nsc_pkg::CH_STAR) begin
        t_star_seen = 1'b1;
      end else begin
        t_xor = running_xor ^ byte_req;
        if (byte_req == nsc_pkg::CH_COMMA) begin
          t_in_header = 1'b0;
          if (comma_total != nsc_pkg::COMMA_W'(nsc_pkg::MAX_FIELDS - 1)) begin
            t_commas = comma_total + 1'b1;
          end
        end else if (in_header) begin
          t_tail = {header_tail[15:0], byte_req};
          if (header_length != 2'd3) begin
            t_hdr_len = header_length + 2'd1;
          end
        end
      end
    end else if (hex_digits_taken != 2'd2) begin
      if (!nib[4]) begin
        t_hex_invalid = 1'b1;
      end
      t_sum       = {given_sum[3:0], nib[3:0]};
      t_hex_taken = hex_digits_taken + 2'd1;
    end
  end

  always_comb begin
    v_kind = nsc_pkg::KIND_UNKNOWN;
    if (t_hdr_len == 2'd3) begin
      if (t_tail == nsc_pkg::TAG_RMC) begin
        v_kind = nsc_pkg::KIND_RMC;
      end else if (t_tail == nsc_pkg::TAG_GGA) begin
        v_kind = nsc_pkg::KIND_GGA;
      end else if (t_tail == nsc_pkg::TAG_MWV) begin
        v_kind = nsc_pkg::KIND_MWV;
      end
    end
    v_ok = t_star_seen && (t_hex_taken == 2'd2) && !t_hex_invalid && (t_sum == t_xor);
    // nothing between '$' and '*' counts as zero fields
    if (t_hdr_len == 2'd0 && t_in_header) begin
      v_count = '0;
    end else begin
      v_count = nsc_pkg::COUNT_W'(t_commas) + nsc_pkg::COUNT_W'(1);
    end
    v_count8 = 8'(v_count);
    if (!t_start_good) begin
      v_status = nsc_pkg::ST_BAD_START;
    end else if (!v_ok) begin
      v_status = nsc_pkg::ST_BAD_SUM;
    end else if (t_hdr_len != 2'd3) begin
      v_status = nsc_pkg::ST_SHORT_HDR;
    end else if (v_kind == nsc_pkg::KIND_UNKNOWN) begin
      v_status = nsc_pkg::ST_UNKNOWN_TYPE;
    end else begin
      v_status = nsc_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    at_first_byte_next    = at_first_byte;
    start_good_next       = start_good;
    star_seen_next        = star_seen;
    hex_digits_taken_next = hex_digits_taken;
    running_xor_next      = running_xor;
    given_sum_next        = given_sum;
    hex_invalid_next      = hex_invalid;
    in_header_next        = in_header;
    header_tail_next      = header_tail;
    header_length_next    = header_length;
    comma_total_next      = comma_total;
    if (accept) begin
      if (last) begin
        at_first_byte_next    = 1'b1;
        start_good_next       = 1'b0;
        star_seen_next        = 1'b0;
        hex_digits_taken_next = 2'd0;
        running_xor_next      = 8'd0;
        given_sum_next        = 8'd0;
        hex_invalid_next      = 1'b0;
        in_header_next        = 1'b1;
        header_tail_next      = 24'd0;
        header_length_next    = 2'd0;
        comma_total_next      = '0;
      end else begin
        at_first_byte_next    = 1'b0;
        start_good_next       = t_start_good;
        star_seen_next        = t_star_seen;
        hex_digits_taken_next = t_hex_taken;
        running_xor_next      = t_xor;
        given_sum_next        = t_sum;
        hex_invalid_next      = t_hex_invalid;
        in_header_next        = t_in_header;
        header_tail_next      = t_tail;
        header_length_next    = t_hdr_len;
        comma_total_next      = t_commas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_byte    <= 1'b1;
      start_good       <= 1'b0;
      star_seen        <= 1'b0;
      hex_digits_taken <= 2'd0;
      running_xor      <= 8'd0;
      given_sum        <= 8'd0;
      hex_invalid      <= 1'b0;
      in_header        <= 1'b1;
      header_tail      <= 24'd0;
      header_length    <= 2'd0;
      comma_total      <= '0;
    end else begin
      at_first_byte    <= at_first_byte_next;
      start_good       <= start_good_next;
      star_seen        <= star_seen_next;
      hex_digits_taken <= hex_digits_taken_next;
      running_xor      <= running_xor_next;
      given_sum        <= given_sum_next;
      hex_invalid      <= hex_invalid_next;
      in_header        <= in_header_next;
      header_tail      <= header_tail_next;
      header_length    <= header_length_next;
      comma_total      <= comma_total_next;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      status_q <= v_status;
      kind_q   <= v_kind;
      ok_q     <= v_ok;
      count_q  <= v_count8[5:0];
    end
  end

  assign status        = status_q;
  assign sentence_kind = kind_q;
  assign checksum_ok   = ok_q;
  assign field_count   = count_q;

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> out_valid)
    else $error("last beat did not produce a verdict");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> at_first_byte && !star_seen && in_header)
    else $error("scanner not cleared after last beat");

  a_accepted_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == nsc_pkg::ST_ACCEPTED |->
      checksum_ok && sentence_kind != nsc_pkg::KIND_UNKNOWN)
    else $error("accepted verdict without checksum or known type");

  a_bad_sum_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == nsc_pkg::ST_BAD_SUM |-> !checksum_ok)
    else $error("bad checksum status with checksum_ok set");

endmodule

`default_nettype wire
